// ===== rtl/core/b40sp_pkg.sv =====
// ----------------------------------------------------------------------------
// b40sp_pkg: shared types and constants of the base-40 string packer
// Holds the item and result records, the status codes and the fixed widths.
// ----------------------------------------------------------------------------
package b40sp_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CodeW  = 6;
  localparam int unsigned CountW = 4;

  // -2^63 as an addend, modulo 2^64
  localparam logic [ValueW-1:0] OffsetMin64 = {1'b1, {(ValueW-1){1'b0}}};

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_LONG  = 2'd2,
    STAT_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             absent;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [CodeW-1:0] code;
  } code_t;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/core/b40sp_code_map.sv =====
// ----------------------------------------------------------------------------
// b40sp_code_map: character to base-40 digit
// Maps digits, space, underscore, hyphen, period and A-Z; flags all else.
// ----------------------------------------------------------------------------
module b40sp_code_map (
  input  logic [b40sp_pkg::CharW-1:0] char_code,
  output b40sp_pkg::code_t            code
);

  logic [b40sp_pkg::CharW-1:0] off_digit;
  logic [b40sp_pkg::CharW-1:0] off_alpha;

  assign off_digit = char_code - b40sp_pkg::CharW'(16'h0030);
  assign off_alpha = char_code - b40sp_pkg::CharW'(16'h0041);

  always_comb begin
    code.hit  = 1'b1;
    code.code = '0;
    if (char_code >= 16'h0030 && char_code <= 16'h0039) begin
      code.code = off_digit[b40sp_pkg::CodeW-1:0];
    end else if (char_code == 16'h0020) begin
      code.code = 6'd10;
    end else if (char_code == 16'h005F) begin
      code.code = 6'd11;
    end else if (char_code == 16'h002D) begin
      code.code = 6'd12;
    end else if (char_code == 16'h002E) begin
      code.code = 6'd13;
    end else if (char_code >= 16'h0041 && char_code <= 16'h005A) begin
      code.code = off_alpha[b40sp_pkg::CodeW-1:0] + 6'd14;
    end else begin
      code.hit = 1'b0;
    end
  end

endmodule

// ===== rtl/core/b40sp_fold.sv =====
// ----------------------------------------------------------------------------
// b40sp_fold: running base-40 fold and end-of-string verdict
// Holds the accumulator, character count and bad-character flag.
// ----------------------------------------------------------------------------
module b40sp_fold #(
  parameter int unsigned MAX_CHARS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  b40sp_pkg::item_t    item,
  output b40sp_pkg::result_t  res
);

  localparam logic [b40sp_pkg::CountW-1:0] CntMax = b40sp_pkg::CountW'(MAX_CHARS);
  localparam logic [b40sp_pkg::CountW-1:0] CntSat = b40sp_pkg::CountW'(MAX_CHARS + 1);

  logic [b40sp_pkg::ValueW-1:0] acc_r, acc_nxt, acc_step;
  logic [b40sp_pkg::CountW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                         bad_r, bad_nxt;
  b40sp_pkg::code_t             code;

  b40sp_code_map u_map (
    .char_code (item.char_code),
    .code      (code)
  );

  assign cnt_inc  = (cnt_r < CntSat) ? cnt_r + 1'b1 : cnt_r;
  // times 40 as two shifts and an add
  assign acc_step = (acc_r << 5) + (acc_r << 3)
                  + {{(b40sp_pkg::ValueW-b40sp_pkg::CodeW){1'b0}}, code.code};

  always_comb begin
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    bad_nxt    = bad_r;
    res.valid  = 1'b0;
    res.value  = '0;
    res.status = b40sp_pkg::STAT_OK;
    if (item.absent) begin
      res.valid  = 1'b1;
      res.status = b40sp_pkg::STAT_EMPTY;
      acc_nxt    = '0;
      cnt_nxt    = '0;
      bad_nxt    = 1'b0;
    end else begin
      cnt_nxt = cnt_inc;
      if (cnt_inc <= CntMax) begin
        if (code.hit) begin
          acc_nxt = acc_step;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      if (item.last) begin
        res.valid = 1'b1;
        if (cnt_inc > CntMax) begin
          res.status = b40sp_pkg::STAT_LONG;
        end else if (bad_nxt) begin
          res.status = b40sp_pkg::STAT_BAD;
        end else begin
          res.value = acc_nxt + b40sp_pkg::OffsetMin64;
        end
        acc_nxt = '0;
        cnt_nxt = '0;
        bad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      bad_r <= 1'b0;
    end else if (go) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      bad_r <= bad_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntSat)
    else $error("character count beyond saturation");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.valid |=> acc_r == '0 && cnt_r == '0 && !bad_r)
    else $error("state not cleared after a result");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(acc_r) && $stable(cnt_r) && $stable(bad_r))
    else $error("state moved without an item");

endmodule

// ===== rtl/core/base40_string_packer.sv =====
// ----------------------------------------------------------------------------
// base40_string_packer: streams a string in, one packed base-40 word out
// Folds each character as acc*40+code; at the end of the string gives the
// sum offset by -2^63 with a status, or a status alone on an error.
// ----------------------------------------------------------------------------
//
//  channel | tdata              | tuser         | tlast
//  --------+--------------------+---------------+------------------------
//  in_     | [15:0] char_code   | [0] absent    | last character of string
//  out_    | [63:0] packed_value| [1:0] status  | (none)
//
//  One request is taken every cycle when the result side keeps up; the
//  multiply-by-40 fold is a combinational shift-add, so that stage sets
//  the rate. Results pass the input register, then the result register.
//  rst_n is synchronous and active low; it clears the fold state and both
//  valid flags. When the result register is full and stalled, only a
//  request that would give a result waits; plain characters keep flowing.
// ----------------------------------------------------------------------------
module base40_string_packer #(
  parameter int unsigned MAX_CHARS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] char_code
  input  logic [0:0]  in_tuser,   // [0] absent
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] packed_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  // input register: holds one request ahead of the fold
  b40sp_pkg::item_t   inq_r;
  logic               inq_valid_r;
  b40sp_pkg::result_t res;
  logic               stage_go;
  logic               in_fire;

  // result register
  logic [b40sp_pkg::ValueW-1:0] out_value_r;
  b40sp_pkg::status_t           out_status_r;
  logic                         out_valid_r;

  // advance the fold unless it makes a result with nowhere to put it
  assign stage_go  = inq_valid_r && (!res.valid || !out_valid_r || out_tready);
  assign in_tready = !inq_valid_r || stage_go;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_fire) begin
      inq_valid_r <= 1'b1;
    end else if (stage_go) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_r.char_code <= in_tdata;
      inq_r.absent    <= in_tuser[0];
      inq_r.last      <= in_tlast;
    end
  end

  b40sp_fold #(
    .MAX_CHARS (MAX_CHARS)
  ) u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (stage_go),
    .item  (inq_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_go && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && res.valid) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> inq_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room downstream");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != b40sp_pkg::STAT_OK |-> out_value_r == '0)
    else $error("non-zero value on an error status");

  a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r)
    else $error("pending result lost");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for base40_string_packer
// Streams strings of random length and content through the packer, with
// random gaps on both sides, long result back-pressure and a full drain
// pause. A scoreboard folds every accepted request into its own base-40
// sum and checks each result, value and status, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_CHARS    = 12;
  localparam int unsigned COUNT_SAT    = 13;
  localparam int unsigned RANDOM_REQS  = 750;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam longint     RUN_LIMIT    = 2_000_000;

  // Character codes: digit and letter run bounds, punctuation digits, lowercase a
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_UNDER = 16'h005F;
  localparam logic [15:0] CH_DASH  = 16'h002D;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_UPA   = 16'h0041;
  localparam logic [15:0] CH_UPZ   = 16'h005A;
  localparam logic [15:0] CH_LOWA  = 16'h0061;

  typedef struct {
    logic [63:0]        value;
    b40sp_pkg::status_t status;
  } packed_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the fold state and the queue of awaited words
  // --------------------------------------------------------------------------
  class packer_scoreboard;
    logic [63:0]  fold_acc;
    logic [3:0]   chars_seen;
    bit           bad_seen;
    packed_word_t awaited[$];
    int unsigned  errors;

    function new();
      clear_fold();
      errors = 0;
    endfunction

    function void clear_fold();
      fold_acc   = '0;
      chars_seen = '0;
      bad_seen   = 1'b0;
    endfunction

    // Map one character to its base-40 digit; return 0 when it has none
    function bit to_digit(input logic [15:0] ch, output logic [5:0] digit);
      digit = '0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        digit = 6'(ch - CH_ZERO);
        return 1'b1;
      end
      if (ch >= CH_UPA && ch <= CH_UPZ) begin
        digit = 6'(ch - CH_UPA + 16'd14);
        return 1'b1;
      end
      case (ch)
        CH_SPACE: digit = 6'd10;
        CH_UNDER: digit = 6'd11;
        CH_DASH:  digit = 6'd12;
        CH_DOT:   digit = 6'd13;
        default:  return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Fold one accepted request; queue a word when it closes a string
    function void note_request(logic [15:0] ch, logic no_text, logic closing);
      logic [5:0]   digit;
      packed_word_t word;
      word.value = '0;
      if (no_text) begin
        // null string: drop anything pending
        clear_fold();
        word.status = b40sp_pkg::STAT_EMPTY;
        awaited.push_back(word);
        return;
      end
      if (chars_seen != 4'(COUNT_SAT)) chars_seen++;
      if (chars_seen <= MAX_CHARS) begin
        if (to_digit(ch, digit)) fold_acc = fold_acc * 64'd40 + 64'(digit);
        else bad_seen = 1'b1;
      end
      if (!closing) return;
      if (chars_seen > MAX_CHARS) begin
        word.status = b40sp_pkg::STAT_LONG;
      end else if (bad_seen) begin
        word.status = b40sp_pkg::STAT_BAD;
      end else begin
        word.status = b40sp_pkg::STAT_OK;
        word.value  = fold_acc + b40sp_pkg::OffsetMin64;
      end
      awaited.push_back(word);
      clear_fold();
    endfunction

    function void check_result(logic [63:0] value, logic [1:0] status);
      packed_word_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: packed_value %h status %0d", value, status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.value) begin
        $error("packed_value: expected %h, got %h", want.value, value);
        errors++;
      end
      if (status !== 2'(want.status)) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  packer_scoreboard track = new();

  // raised by the stimulus, cleared by the receiver once its hold is over
  bit          hold_req   = 1'b0;
  bit          tx_eager   = 1'b1;
  int unsigned sent       = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  base40_string_packer #(
    .MAX_CHARS(MAX_CHARS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] char_code
    .in_tuser  (in_tuser),   // [0] absent
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [63:0] packed_value
    .out_tuser (out_tuser)   // [1:0] status
  );

  // Idle stretch length: mostly short, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] valid_char();
    int unsigned d;
    d = $urandom_range(0, 39);
    if (d < 10) return CH_ZERO + 16'(d);
    case (d)
      10:      return CH_SPACE;
      11:      return CH_UNDER;
      12:      return CH_DASH;
      13:      return CH_DOT;
      default: return CH_UPA + 16'(d - 14);
    endcase
  endfunction

  // Lowercase, control codes or anything wide: none of them has a digit
  function automatic logic [15:0] invalid_char();
    case ($urandom_range(0, 2))
      0:       return CH_LOWA + 16'($urandom_range(0, 25));
      1:       return 16'($urandom_range(0, 31));
      default: return 16'($urandom_range(16'h0080, 16'hFFFF));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: change inputs at the falling edge, hold until the request is
  // taken, then hand it to the scoreboard
  // --------------------------------------------------------------------------
  task automatic send_request(logic [15:0] ch, logic no_text, logic closing);
    int unsigned gap;
    if (sent % 64 == 0) tx_eager = ($urandom_range(0, 2) == 0);
    gap = (!tx_eager && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= no_text;
    in_tlast  <= closing;
    do @(posedge clk); while (!in_tready);
    track.note_request(ch, no_text, closing);
    sent++;
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++)
      send_request(16'(text[i]), 1'b0, i == text.len() - 1);
  endtask

  // Random string: well-formed mostly, some too long, a few cut short by a
  // null request, the odd bad character
  task automatic send_random_string();
    int unsigned len;
    int unsigned cut;
    logic [15:0] ch;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 12);
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len) : 0;
    for (int unsigned i = 1; i <= len; i++) begin
      if (i == cut) begin
        send_request(16'($urandom_range(0, 16'hFFFF)), 1'b1, 1'($urandom_range(0, 1)));
        return;
      end
      ch = ($urandom_range(0, 24) == 0) ? invalid_char() : valid_char();
      send_request(ch, 1'b0, i == len);
    end
  endtask

  // Drop the request line, then wait for every awaited result
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (track.outstanding() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls in busy stretches, none in calm ones, and a long
  // hold-off whenever the stimulus asks for one
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    int unsigned epoch;
    bit          calm;
    stall_left = 0;
    epoch      = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (epoch == 0) begin
          calm  = ($urandom_range(0, 3) == 0);
          epoch = $urandom_range(50, 200);
        end
        epoch--;
        if (stall_left != 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          stall_left = idle_len() - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Sample results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) track.check_result(out_tdata, out_tuser);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // null string closing with last set
    send_request(16'hFFFF, 1'b1, 1'b1);
    // null request without last drops a pending partial string
    send_request(CH_UPA, 1'b0, 1'b0);
    send_request(16'h0000, 1'b1, 1'b0);
    // the four punctuation digits and the digit 9
    send_text("9 _-.");
    // lowercase is not a digit
    send_request(CH_LOWA, 1'b0, 1'b1);
    // bad character first, valid one after: still a bad string
    send_request(16'hFFFF, 1'b0, 1'b0);
    send_request(CH_ZERO, 1'b0, 1'b1);
    // largest sum: twelve of the top digit
    send_text("ZZZZZZZZZZZZ");
    wait_drained();

    sent = 0;
    while (sent < RANDOM_REQS) begin
      send_random_string();
      // fill the block while the result side holds off
      if (sent >= 200 && sent < 220 && !hold_req) hold_req = 1'b1;
      // in one window, let every result come home before going on
      if (sent >= 450 && sent < 470) wait_drained();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (track.errors == 0 && track.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop should the block hang
  initial begin
    #RUN_LIMIT;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== base40_string_packer.f =====
rtl/core/b40sp_pkg.sv
rtl/core/b40sp_code_map.sv
rtl/core/b40sp_fold.sv
rtl/core/base40_string_packer.sv
bench/testbench.sv
